// ===== rtl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types and constants for the signed target sum counter.
// ----------------------------------------------------------------------------
package stsc_pkg;

    // Counts are kept modulo this prime.
    localparam int unsigned COUNT_MOD  = 32'd1000000007;
    localparam int          COUNT_W    = 30;
    localparam int          ITEM_W     = 8;
    localparam int          TARGET_W   = 13;

    // Status codes carried on the result beat
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PASS   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_LOOKUP = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_CLEAR  = 6'b100000
    } t_state;

endpackage

// ===== rtl/signed_target_sum_counter.sv =====
// ----------------------------------------------------------------------------
// signed_target_sum_counter
// Counts sign assignments of a value list that reach a signed target.
// ----------------------------------------------------------------------------
// One beat is taken when start is high and busy is low. Each value runs one
// downward read-modify-write pass over the count memory, one entry a cycle
// from SUM_LIMIT-1 down to the value, with busy high (a value at or above
// SUM_LIMIT runs no pass and, unless it is marked last, leaves busy low).
// The count memory port is the limit: two reads and one write per cycle.
// On a beat marked last, the lookup and result states look up the answer and
// present it on o_way_count/o_status with o_result_strobe high for exactly
// one cycle; the receiver cannot stall it. A clearing pass then resets the
// memory, and the same pass runs after reset, with busy high throughout. The
// target register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module signed_target_sum_counter
    import stsc_pkg::*;
#(
    parameter int SUM_LIMIT = 4096,
    parameter int VALUE_MAX = 255
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic [ITEM_W-1:0]          i_item_value,
    input  logic                       i_last_item,
    // result channel
    output logic                       o_result_strobe,
    output logic [COUNT_W-1:0]         o_way_count,
    output logic                       o_status,
    // configuration
    input  logic                       i_cfg_we,
    input  logic signed [TARGET_W-1:0] i_target_value
);

    localparam int AW = $clog2(SUM_LIMIT);
    // wide enough for a table index and an item value, plus a carry
    localparam int TW = ((AW > ITEM_W) ? AW : ITEM_W) + 1;
    // signed width for target plus total
    localparam int CW = ((TW > TARGET_W) ? TW : TARGET_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SUM_LIMIT - 1);

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_idx, n_idx;
    logic [ITEM_W-1:0]           r_val, n_val;
    logic                        r_last, n_last;
    logic [AW-1:0]               r_total, n_total;
    logic                        r_ovf, n_ovf;
    logic                        r_hit, n_hit;
    logic signed [TARGET_W-1:0]  r_target;

    logic [COUNT_W-1:0]          r_count_mem [SUM_LIMIT];
    logic [COUNT_W-1:0]          r_rd_a, r_rd_b;
    logic                        r_wr_vld;
    logic [AW-1:0]               r_wr_addr;

    logic                        accept;
    logic [ITEM_W-1:0]           sat_val;
    logic                        pass_empty;
    logic [TW-1:0]               total_sum;
    logic [AW-1:0]               rd_addr_a, rd_addr_b;
    logic                        we;
    logic [AW-1:0]               wr_addr;
    logic [COUNT_W-1:0]          wr_data;
    logic [COUNT_W:0]            add_sum;
    logic [COUNT_W+1:0]          add_red;
    logic [COUNT_W-1:0]          add_mod;
    logic signed [CW-1:0]        tgt_ext, tot_ext, tgt_plus;
    logic                        lookup_ok;
    logic [AW-1:0]               lookup_idx;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Clamp the value to VALUE_MAX
    always_comb begin
        if (32'(i_item_value) > 32'(VALUE_MAX)) begin
            sat_val = ITEM_W'(VALUE_MAX);
        end else begin
            sat_val = i_item_value;
        end
    end

    // A value beyond the table leaves every entry unchanged
    assign pass_empty = (TW'(sat_val) > TW'(SUM_LIMIT - 1));
    assign total_sum  = TW'(r_total) + TW'(sat_val);

    // Target check against the running total
    assign tgt_ext    = CW'(r_target);
    assign tot_ext    = $signed(CW'(r_total));
    assign tgt_plus   = tgt_ext + tot_ext;
    assign lookup_ok  = (tgt_ext <= tot_ext) && (-tgt_ext <= tot_ext) && !tgt_plus[0];
    assign lookup_idx = AW'(tgt_plus >>> 1);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_val   = r_val;
        n_last  = r_last;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_hit   = r_hit;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_val  = sat_val;
                    n_last = i_last_item;
                    n_idx  = LAST_ADDR;
                    if (total_sum > TW'(SUM_LIMIT - 1)) begin
                        n_ovf   = 1'b1;
                        n_total = LAST_ADDR;
                    end else begin
                        n_total = AW'(total_sum);
                    end
                    if (!pass_empty) begin
                        n_state = ST_PASS;
                    end else if (i_last_item) begin
                        n_state = ST_LOOKUP;
                    end
                end
            end
            ST_PASS: begin
                if (TW'(r_idx) == TW'(r_val)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_LOOKUP : ST_IDLE;
            end
            ST_LOOKUP: begin
                n_hit   = !r_ovf && lookup_ok;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                n_total = '0;
                n_ovf   = 1'b0;
                n_idx   = '0;
                n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (r_idx == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_idx    <= '0;
            r_last   <= 1'b0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_hit    <= 1'b0;
            r_wr_vld <= 1'b0;
            r_target <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_last   <= n_last;
            r_total  <= n_total;
            r_ovf    <= n_ovf;
            r_hit    <= n_hit;
            r_wr_vld <= (r_state == ST_PASS);
            if (i_cfg_we) begin
                r_target <= i_target_value;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_wr_addr <= r_idx;
    end

    // Read addresses: entry j and entry j - v, or the answer entry
    assign rd_addr_a = (r_state == ST_LOOKUP) ? lookup_idx : r_idx;
    assign rd_addr_b = r_idx - AW'(r_val);

    // Modular add of the two entries read last cycle
    assign add_sum = {1'b0, r_rd_a} + {1'b0, r_rd_b};
    assign add_red = {1'b0, add_sum} - (COUNT_W + 2)'(COUNT_MOD);
    assign add_mod = add_red[COUNT_W+1] ? add_sum[COUNT_W-1:0] : add_red[COUNT_W-1:0];

    // Write port: pass write-back or clearing pass
    always_comb begin
        if (r_state == ST_CLEAR) begin
            we      = 1'b1;
            wr_addr = r_idx;
            wr_data = (r_idx == '0) ? COUNT_W'(1) : '0;
        end else begin
            we      = r_wr_vld;
            wr_addr = r_wr_addr;
            wr_data = add_mod;
        end
    end

    // Count memory, one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_count_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_count_mem[rd_addr_a];
        r_rd_b <= r_count_mem[rd_addr_b];
    end

    // Result beat
    assign o_result_strobe = (r_state == ST_RESULT);
    assign o_way_count     = r_hit ? r_rd_a : '0;
    assign o_status        = r_ovf ? STATUS_OVERFLOW : STATUS_OK;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed target sum counter.
// Lists of values are sent as command beats, each list ending on a beat marked
// last. A local model keeps its own subset-sum table, running total and
// overflow flag, and predicts each list's answer when that beat is taken. A
// monitor compares every result strobe, field by field, with the oldest
// prediction. The target register is rewritten between lists while the block
// is idle, out to -4095 and 4095.
// ----------------------------------------------------------------------------
module tb;
    import stsc_pkg::*;

    localparam int SUM_LIMIT   = 4096;
    localparam int VALUE_MAX   = 255;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RAND_ITEMS  = 85;
    localparam int IDLE_ITEMS  = 60;

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               status;
    } t_answer;

    // DUT ports
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [ITEM_W-1:0]          i_item_value;
    logic                       i_last_item;
    logic                       o_result_strobe;
    logic [COUNT_W-1:0]         o_way_count;
    logic                       o_status;
    logic                       i_cfg_we;
    logic signed [TARGET_W-1:0] i_target_value;

    // Local model state
    logic [COUNT_W-1:0]         ways_by_sum [SUM_LIMIT];
    int                         sum_so_far;
    bit                         sum_overflowed;
    logic signed [TARGET_W-1:0] target_now;

    t_answer                    pending_answers [$];
    logic [ITEM_W-1:0]          list_vals [$];

    int error_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int lists_run       = 0;
    int overflow_lists  = 0;
    int nonzero_answers = 0;
    int cycle_count     = 0;
    int target_lo       = 0;
    int target_hi       = 0;

    signed_target_sum_counter #(
        .SUM_LIMIT (SUM_LIMIT),
        .VALUE_MAX (VALUE_MAX)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item_value    (i_item_value),
        .i_last_item     (i_last_item),
        .o_result_strobe (o_result_strobe),
        .o_way_count     (o_way_count),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_target_value  (i_target_value)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d answers still expected", $time,
                     pending_answers.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Empty list: one way to reach sum zero
    function automatic void clear_table();
        for (int j = 0; j < SUM_LIMIT; j++)
            ways_by_sum[j] = '0;
        ways_by_sum[0] = COUNT_W'(1);
        sum_so_far     = 0;
        sum_overflowed = 1'b0;
    endfunction

    // Downward pass: each sum may now also include this value
    function automatic void absorb_value(input logic [ITEM_W-1:0] v);
        int          vi;
        int unsigned s;
        vi = (int'(v) > VALUE_MAX) ? VALUE_MAX : int'(v);
        for (int j = SUM_LIMIT - 1; j >= vi; j--) begin
            s = 32'(ways_by_sum[j]) + 32'(ways_by_sum[j - vi]);
            if (s >= COUNT_MOD)
                s -= COUNT_MOD;
            ways_by_sum[j] = s[COUNT_W-1:0];
        end
        if (sum_so_far + vi > SUM_LIMIT - 1) begin
            sum_overflowed = 1'b1;
            sum_so_far     = SUM_LIMIT - 1;
        end else begin
            sum_so_far += vi;
        end
    endfunction

    // Answer for the list just closed; the plus-set sums to (target+total)/2
    function automatic t_answer finish_list();
        t_answer a;
        int      t;
        int      idx;
        a.way_count = '0;
        a.status    = STATUS_OK;
        t = int'(target_now);
        if (sum_overflowed) begin
            a.status = STATUS_OVERFLOW;
            overflow_lists++;
        end else if (t <= sum_so_far && -t <= sum_so_far && ((t + sum_so_far) & 1) == 0) begin
            idx = (t + sum_so_far) / 2;
            if (idx >= 0 && idx < SUM_LIMIT)
                a.way_count = ways_by_sum[idx];
        end
        if (a.way_count != 0)
            nonzero_answers++;
        clear_table();
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n && o_result_strobe === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result beat: count %0d status %0b",
                         $time, o_way_count, o_status);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_way_count !== want.way_count) begin
                    $display("%0t: way_count mismatch: expected %0d actual %0d",
                             $time, want.way_count, o_way_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0b actual %0b",
                             $time, want.status, o_status);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Target write, one cycle of write enable
    task automatic write_target(input int tgt);
        i_cfg_we       <= 1'b1;
        i_target_value <= tgt[TARGET_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        target_now  = tgt[TARGET_W-1:0];
        if (tgt < target_lo) target_lo = tgt;
        if (tgt > target_hi) target_hi = tgt;
    endtask

    // One command beat; start stays high only when the next beat follows at once
    task automatic send_item(input logic [ITEM_W-1:0] v, input logic last,
                             input bit gaps_on);
        int gap;
        start        <= 1'b1;
        i_item_value <= v;
        i_last_item  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        absorb_value(v);
        if (last)
            pending_answers.push_back(finish_list());
        items_sent++;
        gap = (gaps_on && $urandom_range(0, 1)) ? int'($urandom_range(1, 13)) : 0;
        if (last || gap != 0)
            start <= 1'b0;
        if (gap != 0) begin
            // sometimes let the pass finish so the gap lands on an idle block
            if ($urandom_range(0, 1))
                do @(posedge i_clk); while (busy !== 1'b0);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for idle, set the target, send list_vals, wait for the answer
    task automatic run_list(input int tgt, input bit gaps_on);
        int n;
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_target(tgt);
        n = list_vals.size();
        for (int k = 0; k < n; k++)
            send_item(list_vals[k], k == n - 1, gaps_on);
        while (pending_answers.size() != 0) @(posedge i_clk);
        list_vals.delete();
        lists_run++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lists with a reachable target, zero, full-scale and negative targets
    task automatic test_basic_counts();
        list_vals = '{8'd0};
        run_list(0, 1'b0);
        list_vals = '{8'd255};
        run_list(255, 1'b1);
        list_vals = '{8'd1, 8'd2};
        run_list(-3, 1'b1);
    endtask

    // Odd parity and targets beyond the total, both signs at the extremes
    task automatic test_no_solution();
        list_vals = '{8'd1, 8'd2};
        run_list(2, 1'b1);
        list_vals = '{8'd255};
        run_list(-4095, 1'b0);
        list_vals = '{8'd3};
        run_list(4095, 1'b1);
    endtask

    // Total one past the table end
    task automatic test_total_overflow();
        repeat (16) list_vals.push_back(8'd255);
        list_vals.push_back(8'd16);
        run_list(100, 1'b1);
    endtask

    // Zeros double every count, so the count passes the modulus
    task automatic test_count_wrap();
        repeat (32) list_vals.push_back(8'd0);
        run_list(0, 1'b0);
    endtask

    // Random lists, mostly with a target that some sign choice reaches
    task automatic test_random_lists();
        int                base;
        int                n;
        int                total;
        int                tgt;
        int                sel;
        logic [ITEM_W-1:0] v;
        base = items_sent;
        while (items_sent - base < RAND_ITEMS) begin
            n     = $urandom_range(1, 5);
            total = 0;
            tgt   = 0;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = '1;
                    2, 3:    v = ITEM_W'($urandom_range(0, 15));
                    default: v = ITEM_W'($urandom_range(0, 255));
                endcase
                list_vals.push_back(v);
                total += int'(v);
                tgt   += $urandom_range(0, 1) ? int'(v) : -int'(v);
            end
            sel = $urandom_range(0, 7);
            if (sel == 6)
                tgt = int'($urandom_range(0, 2 * total)) - total;
            else if (sel == 7)
                tgt = int'($urandom_range(0, 8190)) - 4095;
            run_list(tgt, (items_sent - base) < IDLE_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        start          <= 1'b0;
        i_item_value   <= '0;
        i_last_item    <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_target_value <= '0;
        i_rst_n        <= 1'b0;
        clear_table();
        target_now = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // block clears its table after reset with busy high
        repeat (3) @(posedge i_clk);

        test_basic_counts();
        test_no_solution();
        test_total_overflow();
        test_count_wrap();
        test_random_lists();

        // drain: answers in, clearing pass done, then a short quiet window
        while (pending_answers.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (pending_answers.size() != 0) begin
            $display("%0t: %0d answers never arrived", $time, pending_answers.size());
            error_count++;
        end

        $display("Sent %0d values in %0d lists, checked %0d results, %0d errors",
                 items_sent, lists_run, results_checked, error_count);
        $display("Nonzero counts %0d, overflowed lists %0d, targets %0d..%0d",
                 nonzero_answers, overflow_lists, target_lo, target_hi);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
